// ----- src/skysv_pkg.sv -----
// shared types and constants of the skyline triangular solver
package skysv_pkg;

  typedef enum logic [2:0] {
    OP_PTR   = 3'd0,
    OP_LOWER = 3'd1,
    OP_UPPER = 3'd2,
    OP_DIAG  = 3'd3,
    OP_RHS   = 3'd4,
    OP_START = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FWD = 2'd1,
    ST_BCK = 2'd2
  } status_e;

  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_THR  = 1'b1;

  typedef struct packed {
    logic idle;
    logic ptr_rd;
    logic ptr_hi;
    logic ptr_row_j;
    logic ptr_lo_ld;
    logic fwd_len;
    logic mac_issue;
    logic back_issue;
    logic diag_rd;
    logic back_pass;
    logic div_start;
    logic y_wr;
    logic x_wr;
    logic emit_rd;
    logic emit_ld;
    logic stat_ld;
  } skysv_cmd_t;

  typedef struct packed {
    logic start;
    logic mac_done;
    logic drained;
    logic small_div;
    logic div_done;
    logic row_last;
    logic row_zero;
    logic j_end;
    logic out_free;
    logic emit_last;
  } skysv_sts_t;

endpackage

// ----- src/skysv_if.sv -----
// input and output channel interfaces of the skyline solver
interface skysv_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [10:0]       slot;
  logic [10:0]       profile_start;
  logic signed [31:0] entry_value;

  modport source (output valid, opcode, slot, profile_start, entry_value, input ready);
  modport sink (input valid, opcode, slot, profile_start, entry_value, output ready);
endinterface

interface skysv_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        solution_index;
  logic signed [31:0] solution_value;
  logic [1:0]        status;
  logic              last;

  modport source (output valid, solution_index, solution_value, status, last, input ready);
  modport sink (input valid, solution_index, solution_value, status, last, output ready);
endinterface

// ----- src/skysv_ram.sv -----
// generic single write port ram with registered read
module skysv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/skysv_div.sv -----
// radix-2 restoring divider, 64 by 32 bit, truncating and saturating to 32 bits
module skysv_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic        busy_q, busy_d;
  logic        fin_q, fin_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [31:0] dmag_q, dmag_d;
  logic        neg_q, neg_d;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;
  logic        hi_set;

  assign rem_sh  = {rem_q, num_q[63]};
  assign rem_sub = rem_sh - {1'b0, dmag_q};
  assign ge      = rem_sh >= {1'b0, dmag_q};

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = num_i[63] ? (64'd0 - num_i) : num_i;
      dmag_d = den_i[31] ? (32'd0 - den_i) : den_i;
      neg_d  = num_i[63] ^ den_i[31];
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[31:0] : rem_sh[31:0];
      num_d = {num_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
  end

  // saturate the magnitude, then apply the sign
  assign hi_set = |num_q[63:32];

  always_comb begin
    if (neg_q) begin
      if (hi_set || (num_q[31] && (|num_q[30:0]))) begin
        quot_o = 32'h8000_0000;
      end else begin
        quot_o = 32'd0 - num_q[31:0];
      end
    end else begin
      if (hi_set || num_q[31]) begin
        quot_o = 32'h7FFF_FFFF;
      end else begin
        quot_o = num_q[31:0];
      end
    end
  end

  assign done_o = fin_q;

endmodule

// ----- src/skysv_dp.sv -----
// datapath: table memories, index counters, multiply-accumulate, divider and output register
module skysv_dp import skysv_pkg::*; #(
  parameter int MAX_ORDER   = 64,
  parameter int MAX_PROFILE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skysv_in_if.sink    in_chan,
  skysv_out_if.source out_chan,
  input  logic [6:0]  size_i,
  input  logic [30:0] thr_i,
  input  skysv_cmd_t  cmd_i,
  output skysv_sts_t  sts_o
);

  localparam int CW = $clog2(MAX_ORDER + 1);
  localparam int RW = $clog2(MAX_ORDER);
  localparam int PW = $clog2(MAX_PROFILE);

  function automatic logic [CW-1:0] prof_len(input logic [10:0] lo, input logic [10:0] hi,
                                             input logic [CW-1:0] row);
    logic [10:0] diff;
    diff = (hi >= lo) ? (hi - lo) : 11'd0;
    return (diff > 11'(row)) ? row : diff[CW-1:0];
  endfunction

  logic          in_fire;
  logic          out_fire;
  logic [CW-1:0] i_q, i_d, j_q, j_d, c_q, c_d, k_q, k_d, n_q, n_d;
  logic [CW-1:0] len_q, len_d;
  logic [10:0]   lo_q, lo_d, base_q, base_d;
  logic          rv_q, pv_q;
  logic          oor_q, back_q;
  logic [63:0]   prod_q, acc_q;
  logic          out_valid_q;
  logic [5:0]    out_idx_q;
  logic [31:0]   out_val_q;
  logic [1:0]    out_st_q;
  logic          out_last_q;

  logic [10:0]   ptr_dout;
  logic [31:0]   lo_dout, up_dout, diag_dout, rhs_dout, y_dout, x_dout;
  logic [CW-1:0] ptr_row, ptr_raddr;
  logic [11:0]   lo_sum, up_sum;
  logic          fwd_oor, back_oor;
  logic [CW-1:0] y_mac_idx;
  logic [CW-1:0] lenj, first_col, off;
  logic          hit;
  logic          mac_go_f, mac_go_b;
  logic [31:0]   mul_a, mul_b;
  logic [31:0]   dmag;
  logic [31:0]   num_src;
  logic [63:0]   numer;
  logic          div_done;
  logic [31:0]   quot;
  logic          acc_clr;

  assign in_fire  = in_chan.valid & in_chan.ready;
  assign out_fire = out_chan.valid & out_chan.ready;
  assign in_chan.ready = cmd_i.idle;

  // table writes from load transfers
  logic ptr_we, lo_we, up_we, diag_we, rhs_we;
  assign ptr_we  = in_fire && (in_chan.opcode == OP_PTR) && (32'(in_chan.slot) <= MAX_ORDER);
  assign lo_we   = in_fire && (in_chan.opcode == OP_LOWER) && (32'(in_chan.slot) < MAX_PROFILE);
  assign up_we   = in_fire && (in_chan.opcode == OP_UPPER) && (32'(in_chan.slot) < MAX_PROFILE);
  assign diag_we = in_fire && (in_chan.opcode == OP_DIAG) && (32'(in_chan.slot) < MAX_ORDER);
  assign rhs_we  = in_fire && (in_chan.opcode == OP_RHS) && (32'(in_chan.slot) < MAX_ORDER);

  // address generation
  assign ptr_row   = cmd_i.ptr_row_j ? j_q : i_q;
  assign ptr_raddr = cmd_i.ptr_hi ? CW'(ptr_row + 1'b1) : ptr_row;

  assign lo_sum    = 12'(base_q) + 12'(c_q);
  assign fwd_oor   = 32'(lo_sum) >= MAX_PROFILE;
  assign y_mac_idx = i_q - len_q + c_q;
  assign mac_go_f  = cmd_i.mac_issue && (c_q != len_q);

  assign lenj      = prof_len(lo_q, ptr_dout, j_q);
  assign first_col = j_q - lenj;
  assign hit       = i_q >= first_col;
  assign off       = i_q - first_col;
  assign up_sum    = 12'(lo_q) + 12'(off);
  assign back_oor  = 32'(up_sum) >= MAX_PROFILE;
  assign mac_go_b  = cmd_i.back_issue && hit;

  skysv_ram #(.WIDTH(11), .DEPTH(MAX_ORDER + 1)) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (CW'(in_chan.slot)),
    .wdata_i (in_chan.profile_start),
    .re_i    (cmd_i.ptr_rd),
    .raddr_i (ptr_raddr),
    .rdata_o (ptr_dout)
  );

  skysv_ram #(.WIDTH(32), .DEPTH(MAX_PROFILE)) u_lower_ram (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (PW'(in_chan.slot)),
    .wdata_i (in_chan.entry_value),
    .re_i    (mac_go_f),
    .raddr_i (PW'(lo_sum)),
    .rdata_o (lo_dout)
  );

  skysv_ram #(.WIDTH(32), .DEPTH(MAX_PROFILE)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (PW'(in_chan.slot)),
    .wdata_i (in_chan.entry_value),
    .re_i    (mac_go_b),
    .raddr_i (PW'(up_sum)),
    .rdata_o (up_dout)
  );

  skysv_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_diag_ram (
    .clk_i   (clk_i),
    .we_i    (diag_we),
    .waddr_i (RW'(in_chan.slot)),
    .wdata_i (in_chan.entry_value),
    .re_i    (cmd_i.diag_rd),
    .raddr_i (RW'(i_q)),
    .rdata_o (diag_dout)
  );

  skysv_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_rhs_ram (
    .clk_i   (clk_i),
    .we_i    (rhs_we),
    .waddr_i (RW'(in_chan.slot)),
    .wdata_i (in_chan.entry_value),
    .re_i    (cmd_i.diag_rd & ~cmd_i.back_pass),
    .raddr_i (RW'(i_q)),
    .rdata_o (rhs_dout)
  );

  skysv_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.y_wr & div_done),
    .waddr_i (RW'(i_q)),
    .wdata_i (quot),
    .re_i    (mac_go_f | (cmd_i.diag_rd & cmd_i.back_pass)),
    .raddr_i (cmd_i.mac_issue ? RW'(y_mac_idx) : RW'(i_q)),
    .rdata_o (y_dout)
  );

  skysv_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.x_wr & div_done),
    .waddr_i (RW'(i_q)),
    .wdata_i (quot),
    .re_i    (mac_go_b | cmd_i.emit_rd),
    .raddr_i (cmd_i.back_issue ? RW'(j_q) : RW'(k_q)),
    .rdata_o (x_dout)
  );

  // multiply-accumulate
  assign mul_a   = oor_q ? 32'd0 : (back_q ? up_dout : lo_dout);
  assign mul_b   = back_q ? x_dout : y_dout;
  assign acc_clr = cmd_i.fwd_len | cmd_i.y_wr | cmd_i.x_wr;

  always_ff @(posedge clk_i) begin
    oor_q  <= mac_go_b ? back_oor : fwd_oor;
    back_q <= mac_go_b;
    prod_q <= 64'($signed(mul_a) * $signed(mul_b));
    if (acc_clr) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // pivot check and divider
  assign dmag    = diag_dout[31] ? (32'd0 - diag_dout) : diag_dout;
  assign num_src = cmd_i.back_pass ? y_dout : rhs_dout;
  assign numer   = {{16{num_src[31]}}, num_src, 16'd0} - acc_q;

  skysv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (numer),
    .den_i   (diag_dout),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // counters
  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    c_d    = c_q;
    k_d    = k_q;
    n_d    = n_q;
    len_d  = len_q;
    lo_d   = lo_q;
    base_d = base_q;
    if (in_fire && (in_chan.opcode == OP_START)) begin
      i_d = '0;
      if (size_i == 7'd0) begin
        n_d = CW'(1);
      end else if (32'(size_i) > MAX_ORDER) begin
        n_d = CW'(MAX_ORDER);
      end else begin
        n_d = CW'(size_i);
      end
    end
    if (cmd_i.ptr_lo_ld) begin
      lo_d = ptr_dout;
    end
    if (cmd_i.fwd_len) begin
      len_d  = prof_len(lo_q, ptr_dout, i_q);
      base_d = lo_q;
      c_d    = '0;
    end
    if (mac_go_f) begin
      c_d = c_q + 1'b1;
    end
    if (cmd_i.back_issue) begin
      j_d = j_q + 1'b1;
    end
    if (cmd_i.y_wr && div_done) begin
      if (sts_o.row_last) begin
        i_d = n_q - 1'b1;
        j_d = n_q;
      end else begin
        i_d = i_q + 1'b1;
      end
    end
    if (cmd_i.x_wr && div_done) begin
      if (i_q == '0) begin
        k_d = '0;
      end else begin
        i_d = i_q - 1'b1;
        j_d = i_q;
      end
    end
    if (cmd_i.emit_ld) begin
      k_d = k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      n_q         <= CW'(1);
      len_q       <= '0;
      rv_q        <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      i_q   <= i_d;
      j_q   <= j_d;
      c_q   <= c_d;
      k_q   <= k_d;
      n_q   <= n_d;
      len_q <= len_d;
      rv_q  <= mac_go_f | mac_go_b;
      pv_q  <= rv_q;
      if (cmd_i.emit_ld || cmd_i.stat_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    base_q <= base_d;
    if (cmd_i.emit_ld) begin
      out_idx_q  <= 6'(k_q);
      out_val_q  <= x_dout;
      out_st_q   <= ST_OK;
      out_last_q <= sts_o.emit_last;
    end else if (cmd_i.stat_ld) begin
      out_idx_q  <= 6'(i_q);
      out_val_q  <= '0;
      out_st_q   <= cmd_i.back_pass ? ST_BCK : ST_FWD;
      out_last_q <= 1'b1;
    end
  end

  assign out_chan.valid          = out_valid_q;
  assign out_chan.solution_index = out_idx_q;
  assign out_chan.solution_value = out_val_q;
  assign out_chan.status         = out_st_q;
  assign out_chan.last           = out_last_q;

  // status toward the controller
  assign sts_o.start     = in_fire && (in_chan.opcode == OP_START);
  assign sts_o.mac_done  = c_q == len_q;
  assign sts_o.drained   = ~rv_q & ~pv_q;
  assign sts_o.small_div = (dmag == 32'd0) || (dmag < {1'b0, thr_i});
  assign sts_o.div_done  = div_done;
  assign sts_o.row_last  = CW'(i_q + 1'b1) == n_q;
  assign sts_o.row_zero  = i_q == '0;
  assign sts_o.j_end     = j_q >= n_q;
  assign sts_o.out_free  = ~out_valid_q | out_chan.ready;
  assign sts_o.emit_last = CW'(k_q + 1'b1) == n_q;

endmodule

// ----- src/skysv_ctrl.sv -----
// controller: sequences the forward pass, back pass and result emission
module skysv_ctrl import skysv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  skysv_sts_t sts_i,
  output skysv_cmd_t cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_FPTR0 = 18'h00002,
    S_FPTR1 = 18'h00004,
    S_FLEN  = 18'h00008,
    S_FMAC  = 18'h00010,
    S_FDIAG = 18'h00020,
    S_FCHK  = 18'h00040,
    S_FDIV  = 18'h00080,
    S_BJ0   = 18'h00100,
    S_BJ1   = 18'h00200,
    S_BJ2   = 18'h00400,
    S_BDIAG = 18'h00800,
    S_BCHK  = 18'h01000,
    S_BDIV  = 18'h02000,
    S_ERD   = 18'h04000,
    S_ELD   = 18'h08000,
    S_FSTAT = 18'h10000,
    S_BSTAT = 18'h20000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.idle = 1'b1;
        if (sts_i.start) state_d = S_FPTR0;
      end
      S_FPTR0: begin
        cmd_o.ptr_rd = 1'b1;
        state_d = S_FPTR1;
      end
      S_FPTR1: begin
        cmd_o.ptr_rd    = 1'b1;
        cmd_o.ptr_hi    = 1'b1;
        cmd_o.ptr_lo_ld = 1'b1;
        state_d = S_FLEN;
      end
      S_FLEN: begin
        cmd_o.fwd_len = 1'b1;
        state_d = S_FMAC;
      end
      S_FMAC: begin
        if (sts_i.mac_done) begin
          state_d = S_FDIAG;
        end else begin
          cmd_o.mac_issue = 1'b1;
        end
      end
      S_FDIAG: begin
        if (sts_i.drained) begin
          cmd_o.diag_rd = 1'b1;
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts_i.small_div) begin
          state_d = S_FSTAT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_FDIV;
        end
      end
      S_FDIV: begin
        if (sts_i.div_done) begin
          cmd_o.y_wr = 1'b1;
          state_d = sts_i.row_last ? S_BJ0 : S_FPTR0;
        end
      end
      S_BJ0: begin
        if (sts_i.j_end) begin
          state_d = S_BDIAG;
        end else begin
          cmd_o.ptr_rd    = 1'b1;
          cmd_o.ptr_row_j = 1'b1;
          state_d = S_BJ1;
        end
      end
      S_BJ1: begin
        cmd_o.ptr_rd    = 1'b1;
        cmd_o.ptr_hi    = 1'b1;
        cmd_o.ptr_row_j = 1'b1;
        cmd_o.ptr_lo_ld = 1'b1;
        state_d = S_BJ2;
      end
      S_BJ2: begin
        cmd_o.back_issue = 1'b1;
        state_d = S_BJ0;
      end
      S_BDIAG: begin
        cmd_o.back_pass = 1'b1;
        if (sts_i.drained) begin
          cmd_o.diag_rd = 1'b1;
          state_d = S_BCHK;
        end
      end
      S_BCHK: begin
        cmd_o.back_pass = 1'b1;
        if (sts_i.small_div) begin
          state_d = S_BSTAT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_BDIV;
        end
      end
      S_BDIV: begin
        if (sts_i.div_done) begin
          cmd_o.x_wr = 1'b1;
          state_d = sts_i.row_zero ? S_ERD : S_BJ0;
        end
      end
      S_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = S_ELD;
      end
      S_ELD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d = sts_i.emit_last ? S_IDLE : S_ERD;
        end
      end
      S_FSTAT: begin
        if (sts_i.out_free) begin
          cmd_o.stat_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_BSTAT: begin
        cmd_o.back_pass = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.stat_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/skyline_triangular_solver_unit.sv -----
// Skyline triangular solver: forward then back substitution on a factored LU matrix.
// in_chan carries load transfers (profile pointer, lower entry, upper entry, diagonal,
// right-hand side) and the start transfer; out_chan carries solution entries or status.
// Load transfers are taken one per cycle while the block is idle and produce no result.
// A start transfer drops in_chan.ready until the solve has put its last result into the
// output register. A forward row takes two pointer reads, one multiply-accumulate per
// profile entry, a pipeline drain, a pivot check and a bit-serial divide. A back row
// reads the pointers of each later column and issues its multiply-accumulate, plus the
// same drain, check and divide. Emission reads and then loads each entry.
// The divider, one quotient bit per cycle, sets most of the solve time.
// A too-small pivot ends the solve with one status result (last set, value zero).
// When out_chan.ready is low the result holds in the output register and the walk waits.
// Reset clears the controller, counters, output valid and sets size_q and thr_q to 1;
// table contents are undefined until loaded. The user must make configuration writes
// via cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block does not enforce it.
module skyline_triangular_solver_unit import skysv_pkg::*; #(
  parameter int MAX_ORDER   = 64,
  parameter int MAX_PROFILE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skysv_in_if.sink    in_chan,
  skysv_out_if.source out_chan,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  logic [6:0]  size_q;
  logic [30:0] thr_q;
  skysv_cmd_t  cmd;
  skysv_sts_t  sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 7'd1;
      thr_q  <= 31'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE: size_q <= cfg_data_i[6:0];
        CFG_THR:  thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  skysv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  skysv_dp #(
    .MAX_ORDER   (MAX_ORDER),
    .MAX_PROFILE (MAX_PROFILE)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .size_i   (size_q),
    .thr_i    (thr_q),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );

endmodule

// ----- src/skysv_chk.sv -----
// port-level checker for the skyline solver and its bind
module skysv_chk import skysv_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_last,
  input logic [31:0] out_value
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status != ST_OK) |-> out_last && (out_value == 32'd0))
    else $error("status result not final or not zero");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_opcode == OP_START) |=> !in_ready)
    else $error("input accepted right after start transfer");

  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> out_status == ST_OK)
    else $error("non-final result carries error status");

endmodule

bind skyline_triangular_solver_unit skysv_chk u_skysv_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_opcode  (in_chan.opcode),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_last   (out_chan.last),
  .out_value  (out_chan.solution_value)
);
